@@ hw/rtl/smnt_pkg.sv @@
// Package for the MD tag and NM edit distance generator.
// Holds the column and token payload types, the operation and token codes,
// and the output queue sizing. No dependencies.
package smnt_pkg;

  localparam int BASE_BITS = 8;
  localparam int VALUE_BITS = 20;
  localparam logic [VALUE_BITS-1:0] FIELD_MAX = '1;

  localparam logic [2:0] OP_COMPARE  = 3'd0;
  localparam logic [2:0] OP_EQUAL    = 3'd1;
  localparam logic [2:0] OP_DIFF     = 3'd2;
  localparam logic [2:0] OP_DELETION = 3'd3;
  localparam logic [2:0] OP_INSERT   = 3'd4;

  localparam logic [1:0] TOK_COUNT    = 2'd0;
  localparam logic [1:0] TOK_MISMATCH = 2'd1;
  localparam logic [1:0] TOK_DELMARK  = 2'd2;
  localparam logic [1:0] TOK_DELBASE  = 2'd3;

  localparam int MAX_TOKENS = 4;
  localparam int TOKEN_NUM_BITS = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_BITS = 3;
  localparam int FILL_BITS = PTR_BITS + 1;

  typedef struct packed {
    logic [2:0]           op_kind;
    logic                 op_start;
    logic [BASE_BITS-1:0] query_base;
    logic [BASE_BITS-1:0] ref_base;
    logic                 end_of_alignment;
  } column_t;

  typedef struct packed {
    logic [1:0]            token_kind;
    logic [VALUE_BITS-1:0] token_value;
    logic [VALUE_BITS-1:0] edit_distance;
    logic                  last;
  } token_t;

endpackage

@@ hw/rtl/sam_md_nm_tag_generator.sv @@
// Top level of the MD tag and NM edit distance generator.
// Depends on smnt_pkg for the payload types, codes and queue sizing.
//
// Usage:
//   The in channel takes one alignment column per item (column_t). The out
//   channel gives MD tokens (token_t), one per item, in order. A column
//   yields zero to four tokens; the final column of an alignment always
//   closes with a count token that carries the NM total and last set.
//   Tokens computed for a column are written into an eight-entry output
//   queue at the edge where the column is accepted, so they are queued in
//   the next cycle; the queue drains one token per cycle while out_ready is
//   high. in_ready is high whenever the queue has room for four tokens, so
//   a column can be accepted in every cycle while out_ready keeps the queue
//   drained; the sustained rate is one column per cycle, limited by the
//   single read port of the queue when columns yield more than one token.
//   When the receiver stalls, the queue fills and in_ready drops until four
//   entries are free again; out_data holds steady while out_valid waits.
//   Reset empties the queue and clears the run and edit counters.
module sam_md_nm_tag_generator
  import smnt_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  column_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output token_t  out_data
);

  localparam int WIDE_BITS = (COUNT_BITS > VALUE_BITS) ? COUNT_BITS : VALUE_BITS;

  logic [COUNT_BITS-1:0] match_run;
  logic [COUNT_BITS-1:0] edit_count;
  logic [COUNT_BITS-1:0] run_mid;
  logic [COUNT_BITS-1:0] edit_mid;

  token_t                    queue [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]       wr_ptr;
  logic [PTR_BITS-1:0]       rd_ptr;
  logic [FILL_BITS-1:0]      fill;
  logic [FILL_BITS-1:0]      fill_next;

  token_t                    tok [MAX_TOKENS];
  logic [TOKEN_NUM_BITS-1:0] tok_num;
  logic [TOKEN_NUM_BITS-1:0] push_num;
  logic                      push;
  logic                      pop;
  logic                      bases_equal;
  logic [BASE_BITS-1:0]      ref_upper;
  logic [VALUE_BITS-1:0]     run_field;
  logic [VALUE_BITS-1:0]     run_mid_field;
  logic [VALUE_BITS-1:0]     edit_mid_field;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [VALUE_BITS-1:0] clamp_field(input logic [COUNT_BITS-1:0] v);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(v);
    return (w > WIDE_BITS'(FIELD_MAX)) ? FIELD_MAX : w[VALUE_BITS-1:0];
  endfunction

  assign in_ready  = (fill <= FILL_BITS'(QUEUE_DEPTH - MAX_TOKENS));
  assign push      = in_valid && in_ready;
  assign out_valid = (fill != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = queue[rd_ptr];

  assign bases_equal = (in_data.query_base == in_data.ref_base);
  assign ref_upper   = (in_data.ref_base >= 8'h61 && in_data.ref_base <= 8'h7A) ?
                       in_data.ref_base - 8'h20 : in_data.ref_base;
  assign run_field      = clamp_field(match_run);
  assign run_mid_field  = clamp_field(run_mid);
  assign edit_mid_field = clamp_field(edit_mid);

  always_comb begin
    run_mid  = match_run;
    edit_mid = edit_count;
    tok_num  = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      tok[i] = '0;
    end
    unique case (in_data.op_kind)
      OP_COMPARE, OP_DIFF: begin
        if (in_data.op_kind == OP_COMPARE && bases_equal) begin
          run_mid = sat_inc(match_run);
        end else begin
          tok[0].token_kind  = TOK_COUNT;
          tok[0].token_value = run_field;
          tok[1].token_kind  = TOK_MISMATCH;
          tok[1].token_value = VALUE_BITS'(ref_upper);
          tok_num  = TOKEN_NUM_BITS'(2);
          run_mid  = '0;
          edit_mid = sat_inc(edit_count);
        end
      end
      OP_EQUAL: begin
        run_mid = sat_inc(match_run);
      end
      OP_DELETION: begin
        if (in_data.op_start) begin
          tok[0].token_kind  = TOK_COUNT;
          tok[0].token_value = run_field;
          tok[1].token_kind  = TOK_DELMARK;
          tok[2].token_kind  = TOK_DELBASE;
          tok[2].token_value = VALUE_BITS'(in_data.ref_base);
          tok_num = TOKEN_NUM_BITS'(3);
          run_mid = '0;
        end else begin
          tok[0].token_kind  = TOK_DELBASE;
          tok[0].token_value = VALUE_BITS'(in_data.ref_base);
          tok_num = TOKEN_NUM_BITS'(1);
        end
        edit_mid = sat_inc(edit_count);
      end
      OP_INSERT: begin
        edit_mid = sat_inc(edit_count);
      end
      default: begin
      end
    endcase
    if (in_data.end_of_alignment) begin
      tok[tok_num[1:0]].token_kind    = TOK_COUNT;
      tok[tok_num[1:0]].token_value   = run_mid_field;
      tok[tok_num[1:0]].edit_distance = edit_mid_field;
      tok[tok_num[1:0]].last          = 1'b1;
      tok_num = tok_num + TOKEN_NUM_BITS'(1);
    end
  end

  assign push_num  = push ? tok_num : '0;
  assign fill_next = fill + FILL_BITS'(push_num) - FILL_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_run  <= '0;
      edit_count <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill       <= '0;
    end else begin
      if (push) begin
        match_run  <= in_data.end_of_alignment ? '0 : run_mid;
        edit_count <= in_data.end_of_alignment ? '0 : edit_mid;
        wr_ptr     <= wr_ptr + PTR_BITS'(tok_num);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
        if (TOKEN_NUM_BITS'(i) < tok_num) begin
          queue[wr_ptr + PTR_BITS'(i)] <= tok[i];
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_BITS'(QUEUE_DEPTH))
    else $error("output queue fill above its depth");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.end_of_alignment) |=>
      (match_run == '0 && edit_count == '0))
    else $error("counters not cleared after the final column");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(in_valid && in_ready)) |=>
      (fill == $past(fill) - FILL_BITS'(1)))
    else $error("queue fill did not drop by one on a lone read");

  a_end_pushes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.end_of_alignment && !(out_valid && out_ready)) |=>
      (fill > $past(fill)))
    else $error("final column wrote no closing token");

endmodule
